[rtl/core/utxwin_pkg.sv]
package utxwin_pkg;

   localparam int DEPTH_DEFAULT = 64;

   // Lead byte of the acknowledge pattern after reset ('%', the host value).
   localparam logic [7:0] ACK_LEAD_RESET = 8'h25;
   localparam logic [7:0] ACK_SECOND     = 8'h41;
   localparam logic [7:0] ACK_ZERO       = 8'h00;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_RECV  = 2'd1,
      KIND_SLOT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } utxwin_cmd_type;

   function automatic logic [7:0] expected_byte(input logic [1:0] pos, input logic [7:0] lead);
      logic [7:0] result;
      unique case (pos)
         2'd0:    result = lead;
         2'd1:    result = ACK_SECOND;
         default: result = ACK_ZERO;
      endcase
      return result;
   endfunction

endpackage

[rtl/core/utxwin_ctrl.sv]
module utxwin_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output utxwin_pkg::utxwin_cmd_type cmd
);
   import utxwin_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = req_ready && req_valid;
   assign cmd.execute = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   // A captured transfer is always executed on the next cycle.
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("captured item was not executed");

   // No new transfer is taken while a result is still offered.
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("input ready while result pending");

endmodule

[rtl/core/utxwin_dp.sv]
module utxwin_dp #(
   parameter int DEPTH = utxwin_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  utxwin_pkg::utxwin_cmd_type cmd,
   input  logic [1:0]                 req_kind,
   input  logic [7:0]                 req_data,
   input  logic                       req_end_of_message,
   input  logic                       csr_write_enable,
   input  logic [7:0]                 csr_write_data,
   output logic                       rsp_tx_valid,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_accepted,
   output logic [6:0]                 rsp_queue_count,
   output logic                       rsp_awaiting_ack,
   output logic                       rsp_ack_matched,
   output logic                       rsp_message_done
);
   import utxwin_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

   logic [7:0]    queue_mem [DEPTH];
   logic [7:0]    rd_data_ff;

   logic [1:0]    kind_ff;
   logic [7:0]    data_ff;
   logic          eom_ff;

   logic [7:0]    ack_lead_ff;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] win_ff, win_in;
   logic [1:0]    match_pos_ff, match_pos_in;
   logic          ack_ff, ack_in;
   logic          final_wait_ff, final_wait_in;

   logic          tx_valid_ff, accepted_ff, awaiting_ff, matched_ff, done_ff;
   logic [6:0]    queue_count_ff;

   logic          do_write, do_recv, do_send, byte_hit, matched;
   logic          ack_mid, final_wait_mid, done, restart, awaiting_in;
   logic [CW-1:0] fill_mid, win_mid;
   logic [CW+6:0] fill_ext;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr);
      return (ptr == LAST_PTR) ? '0 : ptr + PW'(1);
   endfunction

   always_comb begin
      do_write = (kind_ff == KIND_WRITE) && (fill_ff != FULL_COUNT);
      do_recv  = (kind_ff == KIND_RECV);
      do_send  = (kind_ff == KIND_SLOT) && (fill_ff != '0) && (win_ff != FULL_COUNT);

      byte_hit = (data_ff == expected_byte(match_pos_ff, ack_lead_ff));
      matched  = do_recv && byte_hit && (match_pos_ff == 2'd3);

      // The matcher restarts on the lead byte; position three wraps to zero.
      match_pos_in = match_pos_ff;
      if (do_recv) begin
         priority if (byte_hit) begin
            match_pos_in = match_pos_ff + 2'd1;
         end else if (data_ff == ack_lead_ff) begin
            match_pos_in = 2'd1;
         end else begin
            match_pos_in = 2'd0;
         end
      end

      wr_ptr_in = do_write ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_send ? advance(rd_ptr_ff) : rd_ptr_ff;

      priority if (do_write) begin
         fill_mid = fill_ff + CW'(1);
      end else if (do_send) begin
         fill_mid = fill_ff - CW'(1);
      end else begin
         fill_mid = fill_ff;
      end
      fill_in = fill_mid;

      win_mid        = do_send ? win_ff + CW'(1) : win_ff;
      ack_mid        = ack_ff || matched;
      final_wait_mid = final_wait_ff || (do_write && eom_ff);

      // A latched acknowledge is spent on the final wait first, then on a full window.
      done    = ack_mid && final_wait_mid && (fill_mid == '0);
      restart = ack_mid && !done && (win_mid == FULL_COUNT);

      final_wait_in = done ? 1'b0 : final_wait_mid;
      win_in        = (done || restart) ? '0 : win_mid;
      ack_in        = (done || restart) ? 1'b0 : ack_mid;
      awaiting_in   = ((win_in == FULL_COUNT) || final_wait_in) && !ack_in;

      fill_ext = {7'd0, fill_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_lead_ff   <= ACK_LEAD_RESET;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         win_ff        <= '0;
         match_pos_ff  <= '0;
         ack_ff        <= 1'b0;
         final_wait_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ack_lead_ff <= csr_write_data;
         end
         if (cmd.execute) begin
            wr_ptr_ff     <= wr_ptr_in;
            rd_ptr_ff     <= rd_ptr_in;
            fill_ff       <= fill_in;
            win_ff        <= win_in;
            match_pos_ff  <= match_pos_in;
            ack_ff        <= ack_in;
            final_wait_ff <= final_wait_in;
         end
      end
   end

   // The oldest byte is read when the item is captured so it is ready for a slot.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         data_ff    <= req_data;
         eom_ff     <= req_end_of_message;
         rd_data_ff <= queue_mem[rd_ptr_ff];
      end
      if (cmd.execute && do_write) begin
         queue_mem[wr_ptr_ff] <= data_ff;
      end
      if (cmd.execute) begin
         tx_valid_ff    <= do_send;
         accepted_ff    <= do_write;
         queue_count_ff <= fill_ext[6:0];
         awaiting_ff    <= awaiting_in;
         matched_ff     <= matched;
         done_ff        <= done;
      end
   end

   assign rsp_tx_valid     = tx_valid_ff;
   assign rsp_tx_byte      = tx_valid_ff ? rd_data_ff : 8'd0;
   assign rsp_accepted     = accepted_ff;
   assign rsp_queue_count  = queue_count_ff;
   assign rsp_awaiting_ack = awaiting_ff;
   assign rsp_ack_matched  = matched_ff;
   assign rsp_message_done = done_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("queue fill count beyond depth");

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      win_ff <= FULL_COUNT)
      else $error("window count beyond depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

[rtl/core/uart_tx_window_ack_flow_control.sv]
// Transmit side of a UART link with a credit window.
// Input channel req_*: one transfer per event. req_kind selects a queue write
// (req_data, req_end_of_message), a byte received from the line (req_data) or
// a line-ready slot. Each input transfer yields exactly one rsp_* transfer that
// reports the byte sent, write acceptance, queue fill and acknowledge status.
// csr_write_enable/csr_write_data set the lead byte of the acknowledge pattern;
// write it only while no item is in flight.
// Sequence: an item is captured, executed on the next cycle and offered on the
// cycle after; a new item is taken only once the previous result has been
// accepted on rsp_ready. The pace is set by the capture, execute and respond
// steps of the controller around the queue memory's registered read port.
// Only one item is in flight; while rsp_valid waits for rsp_ready the
// result holds and req_ready stays low.
// Reset (synchronous, active high) empties the queue, clears the window, the
// matcher, the latched acknowledge and the final wait, and loads the lead byte
// with '%'. Queue memory contents are not cleared; no clearing pass is needed.
module uart_tx_window_ack_flow_control #(
   parameter int DEPTH = utxwin_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_accepted,
   output logic [6:0] rsp_queue_count,
   output logic       rsp_awaiting_ack,
   output logic       rsp_ack_matched,
   output logic       rsp_message_done,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import utxwin_pkg::*;

   utxwin_cmd_type cmd;

   utxwin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   utxwin_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_kind           (req_kind),
      .req_data           (req_data),
      .req_end_of_message (req_end_of_message),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_accepted       (rsp_accepted),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_awaiting_ack   (rsp_awaiting_ack),
      .rsp_ack_matched    (rsp_ack_matched),
      .rsp_message_done   (rsp_message_done)
   );

endmodule

[verif/utxwin_checker.sv]
module utxwin_checker #(
   parameter int DEPTH = utxwin_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data,
   input  logic       req_end_of_message,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_tx_valid,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_accepted,
   input  logic [6:0] rsp_queue_count,
   input  logic       rsp_awaiting_ack,
   input  logic       rsp_ack_matched,
   input  logic       rsp_message_done,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         pending_count,
   output int         error_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import utxwin_pkg::*;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       accepted;
      logic [6:0] queue_count;
      logic       awaiting_ack;
      logic       ack_matched;
      logic       message_done;
   } link_report_type;

   // Shadow copy of the transmit link state.
   logic [7:0] queue_mem [DEPTH];
   int         wr_ptr;
   int         rd_ptr;
   int         fill;
   int         sent;
   int         match_pos;
   bit         ack_latched;
   bit         final_armed;
   logic [7:0] lead;

   link_report_type tx_reports [$];
   int              reported;

   initial begin
      pending_count = 0;
      error_count   = 0;
      reported      = 0;
   end

   function automatic link_report_type step_link(input logic [1:0] kind,
                                                 input logic [7:0] data,
                                                 input logic eom);
      link_report_type r;
      logic [7:0]      want;
      r = '0;
      case (kind)
         KIND_WRITE: begin
            if (fill < DEPTH) begin
               queue_mem[wr_ptr] = data;
               wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
               fill++;
               r.accepted = 1'b1;
               if (eom) final_armed = 1'b1;
            end
         end
         KIND_RECV: begin
            want = (match_pos == 0) ? lead : (match_pos == 1) ? ACK_SECOND : ACK_ZERO;
            if (data == want) begin
               if (match_pos == 3) begin
                  match_pos     = 0;
                  r.ack_matched = 1'b1;
                  ack_latched   = 1'b1;
               end else begin
                  match_pos = match_pos + 1;
               end
            end else if (data == lead) begin
               // A stray lead byte restarts the pattern rather than clearing it.
               match_pos = 1;
            end else begin
               match_pos = 0;
            end
         end
         KIND_SLOT: begin
            if (fill > 0 && sent < DEPTH) begin
               r.tx_byte  = queue_mem[rd_ptr];
               r.tx_valid = 1'b1;
               rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
               fill--;
               sent++;
            end
         end
         default: ;
      endcase

      // A latched acknowledge is only spent once it has something to release.
      if (ack_latched) begin
         if (final_armed && fill == 0) begin
            final_armed    = 1'b0;
            sent           = 0;
            ack_latched    = 1'b0;
            r.message_done = 1'b1;
         end else if (sent >= DEPTH) begin
            sent        = 0;
            ack_latched = 1'b0;
         end
      end

      r.queue_count  = 7'(fill);
      r.awaiting_ack = (sent >= DEPTH || final_armed) && !ack_latched;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      link_report_type got;
      link_report_type want;
      if (reset) begin
         wr_ptr      = 0;
         rd_ptr      = 0;
         fill        = 0;
         sent        = 0;
         match_pos   = 0;
         ack_latched = 1'b0;
         final_armed = 1'b0;
         lead        = ACK_LEAD_RESET;
         tx_reports.delete();
      end else begin
         if (csr_write_enable) lead = csr_write_data;
         // The result transfer always belongs to an older item, so retire it first.
         if (rsp_valid && rsp_ready) begin
            got = {rsp_tx_valid, rsp_tx_byte, rsp_accepted, rsp_queue_count,
                   rsp_awaiting_ack, rsp_ack_matched, rsp_message_done};
            if (tx_reports.size() == 0) begin
               error_count++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: result transfer with nothing outstanding: %h", $realtime, got);
               end
            end else begin
               want = tx_reports.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: mismatch exp tx %b/%h acc %b cnt %0d wait %b match %b done %b",
                              $realtime, want.tx_valid, want.tx_byte, want.accepted,
                              want.queue_count, want.awaiting_ack, want.ack_matched,
                              want.message_done);
                     $display("%0t:          got tx %b/%h acc %b cnt %0d wait %b match %b done %b",
                              $realtime, got.tx_valid, got.tx_byte, got.accepted,
                              got.queue_count, got.awaiting_ack, got.ack_matched,
                              got.message_done);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            tx_reports.push_back(step_link(req_kind, req_data, req_end_of_message));
      end
      pending_count = tx_reports.size();
   end

endmodule

[verif/testbench.sv]
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import utxwin_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_kind;
   logic [7:0] req_data;
   logic       req_end_of_message;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_accepted;
   logic [6:0] rsp_queue_count;
   logic       rsp_awaiting_ack;
   logic       rsp_ack_matched;
   logic       rsp_message_done;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;
   int         pending_count;
   int         error_count;

   // Set for phases that run back to back on both channels.
   bit         steady;
   logic [7:0] lead;

   uart_tx_window_ack_flow_control u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_data           (req_data),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_accepted       (rsp_accepted),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_awaiting_ack   (rsp_awaiting_ack),
      .rsp_ack_matched    (rsp_ack_matched),
      .rsp_message_done   (rsp_message_done),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   utxwin_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_data           (req_data),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_accepted       (rsp_accepted),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_awaiting_ack   (rsp_awaiting_ack),
      .rsp_ack_matched    (rsp_ack_matched),
      .rsp_message_done   (rsp_message_done),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .pending_count      (pending_count),
      .error_count        (error_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic send_item(input logic [1:0] kind, input logic [7:0] data, input logic eom);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind           <= kind;
      req_data           <= data;
      req_end_of_message <= eom;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Acknowledge pattern for the current lead byte, optionally with one byte spoiled.
   task automatic send_ack(input bit spoil);
      logic [7:0] pattern [4];
      pattern[0] = lead;
      pattern[1] = ACK_SECOND;
      pattern[2] = ACK_ZERO;
      pattern[3] = ACK_ZERO;
      if (spoil) pattern[$urandom_range(0, 3)] = 8'($urandom);
      foreach (pattern[i]) send_item(KIND_RECV, pattern[i], 1'($urandom));
   endtask

   initial begin : result_side
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      logic [7:0] phase_lead [8];
      int         count;
      int         sel;
      int         n;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = KIND_WRITE;
      req_data           = '0;
      req_end_of_message = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      steady             = 1'b0;
      lead               = ACK_LEAD_RESET;
      phase_lead = '{ACK_LEAD_RESET, 8'd94, 8'd0, 8'd255, ACK_SECOND,
                     8'($urandom), 8'($urandom), ACK_LEAD_RESET};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Empty-queue slot, extreme bytes, end of message and the unused kind.
      send_item(KIND_SLOT, 8'hFF, 1'b1);
      send_item(KIND_WRITE, 8'h00, 1'b0);
      send_item(KIND_WRITE, 8'hFF, 1'b0);
      send_item(KIND_WRITE, 8'h5A, 1'b1);
      send_item(KIND_NONE, 8'hFF, 1'b1);
      // Early acknowledge stays latched until the queue drains.
      send_ack(1'b0);
      repeat (4) send_item(KIND_SLOT, 8'h00, 1'b0);
      // A repeated lead byte restarts the matcher.
      send_item(KIND_RECV, lead, 1'b0);
      send_ack(1'b0);
      send_item(KIND_RECV, lead, 1'b0);
      send_item(KIND_RECV, ACK_SECOND, 1'b0);
      send_item(KIND_RECV, ACK_ZERO, 1'b0);
      send_item(KIND_RECV, 8'hFF, 1'b0);
      send_item(KIND_RECV, ACK_SECOND, 1'b0);

      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_count != 0) @(negedge clock);
            repeat (4) @(negedge clock);
            lead = phase_lead[p];
            csr_write_enable <= 1'b1;
            csr_write_data   <= lead;
            @(negedge clock);
            csr_write_enable <= 1'b0;
         end
         steady = (p == 2 || p == 5);
         count  = 0;
         while (count < 124) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
               // Mostly short bursts; an occasional long one overfills the queue.
               n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 16);
               repeat (n) send_item(KIND_WRITE, 8'($urandom), $urandom_range(0, 15) == 0);
               count += n;
            end else if (sel < 62) begin
               n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 16);
               repeat (n) send_item(KIND_SLOT, 8'($urandom), 1'($urandom));
               count += n;
            end else if (sel < 76) begin
               send_ack($urandom_range(0, 3) == 0);
               count += 4;
            end else if (sel < 84) begin
               send_item(KIND_WRITE, 8'($urandom), 1'b1);
               count += 1;
            end else begin
               send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
               count += 1;
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
